>>> rtl/core/dpsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsf_pkg
// shared types and register indexes for the seam finder
// ----------------------------------------------------------------------------
package dpsf_pkg;

  localparam int unsigned RegWidth  = 0;
  localparam int unsigned RegHeight = 1;

  typedef enum logic [3:0] {
    StLoad,
    StGrad,
    StGradA,
    StGradB,
    StGradC,
    StCost,
    StCostA,
    StCostB,
    StPick,
    StPickA,
    StTrace,
    StTraceA
  } state_e;

endpackage

>>> rtl/core/dp_seam_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dp_seam_finder
// minimum-energy vertical seam by dynamic programming over a stored image
// ----------------------------------------------------------------------------
// channel   direction  signals                              transfer when
// pixel     in         start_i busy_o pixel_i               start_i & !busy_o
// seam      out        seam_valid_o seam_column_o ...       seam_valid_o
// config    in         psel_i penable_i pwrite_i paddr_i    psel&penable&pwrite
//
// pixels load one per cycle while start_i is high; a config write wins and
// restarts the load at the first pixel. after the last pixel, busy_o rises:
// a gradient pass reading the four neighbours of each pixel in turn (pixel
// memory has one read port), a cost pass reading the neighbours above in
// turn (one read per neighbour), a pick pass over the columns and a trace
// up the rows; results leave one per row and the receiver cannot stall
// reset clears control state only; memories hold undefined data until written
// ----------------------------------------------------------------------------
module dp_seam_finder #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  pixel_i,
  output logic        seam_valid_o,
  output logic [7:0]  seam_column_o,
  output logic [5:0]  seam_row_o,
  output logic        last_row_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW = XW + YW;
  localparam int unsigned CW = 16;
  localparam int unsigned XC = XW + 1;
  localparam int unsigned YC = YW + 1;

  // configuration registers
  logic [8:0] width_q;
  logic [6:0] height_q;
  logic       cfg_wr;
  logic       cfg_idx;
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign cfg_idx  = paddr_i[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 7'd64;
    end else if (cfg_wr) begin
      if (cfg_idx == 1'(dpsf_pkg::RegWidth))  width_q  <= pwdata_i[8:0];
      if (cfg_idx == 1'(dpsf_pkg::RegHeight)) height_q <= pwdata_i[6:0];
    end
  end

  always_comb begin
    prdata_o = '0;
    if (cfg_idx == 1'(dpsf_pkg::RegWidth))       prdata_o = {23'd0, width_q};
    else if (cfg_idx == 1'(dpsf_pkg::RegHeight)) prdata_o = {25'd0, height_q};
  end

  // clamped sizes
  logic [XC-1:0] w_eff;
  logic [YC-1:0] h_eff;
  always_comb begin
    if (width_q < 9'd2) w_eff = XC'(2);
    else if ({23'd0, width_q} > 32'(MAX_WIDTH)) w_eff = XC'(MAX_WIDTH);
    else w_eff = XC'(width_q);
    if (height_q < 7'd2) h_eff = YC'(2);
    else if ({25'd0, height_q} > 32'(MAX_HEIGHT)) h_eff = YC'(MAX_HEIGHT);
    else h_eff = YC'(height_q);
  end
  logic [XW-1:0] xmax;
  logic [YW-1:0] ymax;
  assign xmax = XW'(w_eff - 1'b1);
  assign ymax = YW'(h_eff - 1'b1);

  // memories
  logic [7:0]    pix_mem  [2**AW];
  logic [XW-1:0] pred_mem [2**AW];
  logic [CW-1:0] cost_mem [2*(2**XW)];
  logic [7:0]    grad_mem [2**AW];

  logic          pix_we,  grad_we, pred_we, cost_we;
  logic [AW-1:0] pix_wa, pix_ra, grad_wa, grad_ra, pred_wa, pred_ra;
  logic [7:0]    pix_wd, pix_rd_q, grad_wd, grad_rd_q;
  logic [XW-1:0] pred_wd, pred_rd_q;
  logic [XW:0]   cost_wa, cost_ra;
  logic [CW-1:0] cost_wd, cost_rd_q;

  always_ff @(posedge clk_i) begin
    if (pix_we) pix_mem[pix_wa] <= pix_wd;
    pix_rd_q <= pix_mem[pix_ra];
    if (grad_we) grad_mem[grad_wa] <= grad_wd;
    grad_rd_q <= grad_mem[grad_ra];
    if (pred_we) pred_mem[pred_wa] <= pred_wd;
    pred_rd_q <= pred_mem[pred_ra];
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    cost_rd_q <= cost_mem[cost_ra];
  end

  // sequencer state
  dpsf_pkg::state_e st_q, st_d;
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [1:0]    n_q, n_d;
  logic [7:0]    a_q, a_d, b_q, b_d;
  logic [8:0]    s_q, s_d;
  logic [CW-1:0] best_q, best_d;
  logic [XW-1:0] bcol_q, bcol_d;
  logic          out_v_d, out_v_q;
  logic [7:0]    out_c_d, out_c_q;
  logic [5:0]    out_r_d, out_r_q;
  logic          out_l_d, out_l_q;

  // neighbour positions
  logic [XW-1:0] xl, xr;
  logic [YW-1:0] yu, yd;
  assign xl = (x_q == '0) ? x_q : x_q - 1'b1;
  assign xr = (x_q == xmax) ? x_q : x_q + 1'b1;
  assign yu = (y_q == '0) ? y_q : y_q - 1'b1;
  assign yd = (y_q == ymax) ? y_q : y_q + 1'b1;

  logic [7:0] d_ab;
  assign d_ab = (a_q > b_q) ? a_q - b_q : b_q - a_q;
  logic [7:0] d_ar;
  assign d_ar = (a_q > pix_rd_q) ? a_q - pix_rd_q : pix_rd_q - a_q;

  // cost neighbour column for step n
  logic [XC-1:0] ncol;
  logic          nvalid;
  assign ncol   = XC'(xl) + XC'(n_q);
  assign nvalid = (ncol <= XC'(xr));
  logic [CW-1:0] init_best;
  assign init_best = CW'({y_q, 8'd0}) + CW'(256);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dpsf_pkg::StLoad;
      x_q <= '0; y_q <= '0; n_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; x_q <= x_d; y_q <= y_d; n_q <= n_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; s_q <= s_d;
    best_q <= best_d; bcol_q <= bcol_d;
    out_c_q <= out_c_d; out_r_q <= out_r_d; out_l_q <= out_l_d;
  end

  always_comb begin
    st_d = st_q; x_d = x_q; y_d = y_q; n_d = n_q;
    a_d = a_q; b_d = b_q; s_d = s_q; best_d = best_q; bcol_d = bcol_q;
    out_v_d = 1'b0; out_c_d = out_c_q; out_r_d = out_r_q; out_l_d = out_l_q;
    pix_we = 1'b0; pix_wa = {y_q, x_q}; pix_wd = pixel_i; pix_ra = {y_q, x_q};
    grad_we = 1'b0; grad_wa = {y_q, x_q}; grad_wd = s_q[8:1]; grad_ra = {y_q, x_q};
    pred_we = 1'b0; pred_wa = {y_q, x_q}; pred_wd = bcol_q; pred_ra = {y_q, x_q};
    cost_we = 1'b0; cost_wa = {y_q[0], x_q}; cost_wd = '0;
    cost_ra = {~y_q[0], ncol[XW-1:0]};
    busy_o = (st_q != dpsf_pkg::StLoad);
    unique case (st_q)
      dpsf_pkg::StLoad: begin
        if (cfg_wr) begin
          x_d = '0; y_d = '0;
        end else if (start_i) begin
          pix_we = 1'b1;
          if (x_q == xmax) begin
            x_d = '0;
            if (y_q == ymax) begin
              y_d = '0; st_d = dpsf_pkg::StGrad;
            end else y_d = y_q + 1'b1;
          end else x_d = x_q + 1'b1;
        end
      end
      // gradient: read left, right, up, down in turn
      dpsf_pkg::StGrad: begin
        pix_ra = {y_q, xl}; st_d = dpsf_pkg::StGradA;
      end
      dpsf_pkg::StGradA: begin
        pix_ra = {y_q, xr}; a_d = pix_rd_q; st_d = dpsf_pkg::StGradB;
      end
      dpsf_pkg::StGradB: begin
        pix_ra = {yu, x_q}; b_d = pix_rd_q; st_d = dpsf_pkg::StGradC;
      end
      dpsf_pkg::StGradC: begin
        pix_ra = {yd, x_q};
        if (n_q == 2'd0) begin
          s_d = {1'b0, d_ab}; a_d = pix_rd_q; n_d = 2'd1;
        end else begin
          s_d = s_q + {1'b0, d_ar}; n_d = 2'd0;
          grad_we = 1'b1; grad_wd = 8'((s_q + {1'b0, d_ar}) >> 1);
          if (x_q == xmax) begin
            x_d = '0;
            if (y_q == ymax) begin
              y_d = '0; st_d = dpsf_pkg::StCost;
            end else begin
              y_d = y_q + 1'b1; st_d = dpsf_pkg::StGrad;
            end
          end else begin
            x_d = x_q + 1'b1; st_d = dpsf_pkg::StGrad;
          end
        end
      end
      // cost: fetch gradient, scan up to three neighbours, write back; the top row writes its gradient
      dpsf_pkg::StCost: begin
        grad_ra = {y_q, x_q}; n_d = 2'd0;
        best_d = init_best; bcol_d = x_q; st_d = dpsf_pkg::StCostA;
      end
      dpsf_pkg::StCostA: begin
        a_d = grad_rd_q;
        if (y_q == '0) begin
          cost_we = 1'b1; cost_wd = CW'(grad_rd_q);
          st_d = dpsf_pkg::StCostB;
        end else begin
          cost_ra = {~y_q[0], ncol[XW-1:0]};
          n_d = 2'd1; st_d = dpsf_pkg::StCostB;
        end
      end
      dpsf_pkg::StCostB: begin
        if (y_q == '0) begin
          n_d = 2'd0;
        end else begin
          if (cost_rd_q < best_q) begin
            best_d = cost_rd_q; bcol_d = XW'(ncol - 1'b1);
          end
          if (nvalid && n_q != 2'd3) begin
            cost_ra = {~y_q[0], ncol[XW-1:0]}; n_d = n_q + 1'b1;
          end else begin
            n_d = 2'd0;
          end
        end
        if (y_q == '0 || !(nvalid && n_q != 2'd3)) begin
          if (y_q != '0) begin
            cost_we = 1'b1;
            cost_wd = ((cost_rd_q < best_q) ? cost_rd_q : best_q) + CW'(a_q);
            pred_we = 1'b1;
            pred_wd = (cost_rd_q < best_q) ? XW'(ncol - 1'b1) : bcol_q;
          end
          if (x_q == xmax) begin
            x_d = '0;
            if (y_q == ymax) begin
              st_d = dpsf_pkg::StPick;
            end else begin
              y_d = y_q + 1'b1; st_d = dpsf_pkg::StCost;
            end
          end else begin
            x_d = x_q + 1'b1; st_d = dpsf_pkg::StCost;
          end
        end
      end
      // pick leftmost minimum of the bottom row
      dpsf_pkg::StPick: begin
        cost_ra = {y_q[0], x_q}; st_d = dpsf_pkg::StPickA;
      end
      dpsf_pkg::StPickA: begin
        if (x_q == '0 || cost_rd_q < best_q) begin
          best_d = cost_rd_q; bcol_d = x_q;
        end
        if (x_q == xmax) begin
          x_d = '0; st_d = dpsf_pkg::StTrace;
        end else begin
          x_d = x_q + 1'b1; st_d = dpsf_pkg::StPick;
        end
      end
      // trace predecessors upward, one result per row
      dpsf_pkg::StTrace: begin
        out_v_d = 1'b1; out_c_d = 8'(bcol_q); out_r_d = 6'(y_q);
        out_l_d = (y_q == '0);
        pred_ra = {y_q, bcol_q};
        st_d = (y_q == '0) ? dpsf_pkg::StLoad : dpsf_pkg::StTraceA;
        if (y_q == '0) begin
          x_d = '0;
        end
      end
      dpsf_pkg::StTraceA: begin
        bcol_d = pred_rd_q; y_d = y_q - 1'b1; st_d = dpsf_pkg::StTrace;
      end
      default: st_d = dpsf_pkg::StLoad;
    endcase
  end

  assign seam_valid_o  = out_v_q;
  assign seam_column_o = out_c_q;
  assign seam_row_o    = out_r_q;
  assign last_row_o    = out_l_q;

  // checks
  a_no_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == dpsf_pkg::StLoad && !$past(st_q == dpsf_pkg::StTrace)) |-> !seam_valid_o)
    else $error("result outside trace");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seam_valid_o && last_row_o) |-> !busy_o)
    else $error("busy after last row");
  a_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seam_valid_o |-> (last_row_o == (seam_row_o == 6'd0)))
    else $error("last row flag mismatch");

endmodule
